[src/ovfs_pkg.sv]
// Shared types and constants for the overwriting FIFO with running sum.
// No dependencies; every other file imports this package.
package ovfs_pkg;

  localparam int DEPTH   = 16;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int LEN_W   = 5;
  localparam int TOTAL_W = 36;
  localparam int KIND_W  = 2;

  typedef enum logic [KIND_W-1:0] {
    OP_ENQ   = 2'd0,
    OP_DEQ   = 2'd1,
    OP_PEEK  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // Control from the sequencer to the cell row.
  typedef struct packed {
    logic             shift;
    logic             load;
    logic [CNT_W-1:0] load_at;
  } row_ctl_t;

  // Control seen by one cell.
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

[src/ovfs_if.sv]
// Valid/ready channel interfaces for the request and response sides.
// Depends on ovfs_pkg.
interface ovfs_req_if import ovfs_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

interface ovfs_rsp_if import ovfs_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [DATA_W-1:0]  data;
  logic                      status;
  logic [LEN_W-1:0]          length;
  logic                      is_empty;
  logic signed [TOTAL_W-1:0] total;

  modport source (output valid, data, status, length, is_empty, total, input ready);
  modport sink   (input valid, data, status, length, is_empty, total, output ready);
endinterface

[src/ovfs_cell.sv]
// One storage cell of the queue row: load a new word or take the neighbor's.
// Depends on ovfs_pkg.
module ovfs_cell import ovfs_pkg::*; (
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic signed [DATA_W-1:0] load_word,
  input  logic signed [DATA_W-1:0] neighbor_word,
  output logic signed [DATA_W-1:0] word
);

  // load wins over shift: a full enqueue shifts and refills the last cell
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      word <= load_word;
    end else if (ctl.shift) begin
      word <= neighbor_word;
    end
  end

endmodule

[src/ovfs_row.sv]
// Row of DEPTH cells; cell 0 always holds the head of the queue.
// Depends on ovfs_pkg and ovfs_cell.
module ovfs_row import ovfs_pkg::*; (
  input  logic                     clk,
  input  row_ctl_t                 ctl,
  input  logic signed [DATA_W-1:0] load_word,
  output logic signed [DATA_W-1:0] head_word
);

  logic signed [DATA_W-1:0] words [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctl_t                cctl;
    logic signed [DATA_W-1:0] nb;

    assign cctl.shift = ctl.shift;
    assign cctl.load  = ctl.load && (ctl.load_at == CNT_W'(i));

    if (i == DEPTH - 1) begin : g_last
      assign nb = '0;
    end else begin : g_mid
      assign nb = words[i+1];
    end

    ovfs_cell u_cell (
      .clk           (clk),
      .ctl           (cctl),
      .load_word     (load_word),
      .neighbor_word (nb),
      .word          (words[i])
    );
  end

  assign head_word = words[0];

endmodule

[src/overwriting_fifo_with_sum_top.sv]
// Top level of the overwriting FIFO with running sum.
// Depends on ovfs_pkg, ovfs_if, ovfs_row (and through it ovfs_cell).
//
// Usage:
//   req channel: one transfer carries an operation (kind) and a value.
//     kind = enqueue, dequeue, peek head or clear. Value matters on enqueue.
//   rsp channel: exactly one transfer per request, in order, carrying the
//     dequeued/peeked word (zero otherwise), an empty-error status, the
//     length and empty flag after the operation, and the sum of all entries.
//   Storage is a row of DEPTH cells shifting toward cell 0, which always
//     holds the head; an enqueue loads the cell at the current count, or the
//     last cell while the whole row shifts when the queue is full (the
//     oldest word drops out and leaves the sum).
//   Timing: the response is registered, valid in the cycle after the transfer.
//   Throughput: one operation per cycle unless the response stalls; count,
//     sum and cell row update with one add and one subtract on the sum.
//   Reset (rst, synchronous): count, sum and response valid clear; cell
//     contents are left as they are and are never read before written.
//   Stall: a single response register sits between the sides. While it
//     holds an untaken response and rsp.ready is low, req.ready is low.
module overwriting_fifo_with_sum_top import ovfs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  ovfs_req_if.sink     req,
  ovfs_rsp_if.source   rsp
);

  logic [CNT_W-1:0]          count, count_next;
  logic signed [TOTAL_W-1:0] sum, sum_next;
  logic                      rsp_valid;

  logic signed [DATA_W-1:0]  head_word;
  row_ctl_t                  row_ctl;

  logic                      accept;
  logic                      full;
  logic                      empty;
  logic signed [TOTAL_W-1:0] value_ext;
  logic signed [TOTAL_W-1:0] head_ext;
  logic signed [DATA_W-1:0]  data_next;
  logic                      status_next;

  assign accept    = req.valid && req.ready;
  assign req.ready = !rsp_valid || rsp.ready;

  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign value_ext = TOTAL_W'(req.value);
  assign head_ext  = TOTAL_W'(head_word);

  // Operation decode: next count, sum, row control and response payload.
  always_comb begin
    count_next      = count;
    sum_next        = sum;
    data_next       = '0;
    status_next     = 1'b0;
    row_ctl.shift   = 1'b0;
    row_ctl.load    = 1'b0;
    row_ctl.load_at = count;
    unique case (op_t'(req.kind))
      OP_ENQ: begin
        row_ctl.load = accept;
        if (full) begin
          // evict head: everything moves down, new word lands in last cell
          row_ctl.shift   = accept;
          row_ctl.load_at = CNT_W'(DEPTH - 1);
          sum_next        = sum + value_ext - head_ext;
        end else begin
          count_next = count + CNT_W'(1);
          sum_next   = sum + value_ext;
        end
      end
      OP_DEQ: begin
        if (empty) begin
          status_next = 1'b1;
        end else begin
          data_next     = head_word;
          row_ctl.shift = accept;
          count_next    = count - CNT_W'(1);
          sum_next      = sum - head_ext;
        end
      end
      OP_PEEK: begin
        if (empty) begin
          status_next = 1'b1;
        end else begin
          data_next = head_word;
        end
      end
      OP_CLEAR: begin
        count_next = '0;
        sum_next   = '0;
      end
      default: begin
      end
    endcase
  end

  ovfs_row u_row (
    .clk       (clk),
    .ctl       (row_ctl),
    .load_word (req.value),
    .head_word (head_word)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      sum       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
        sum   <= sum_next;
      end
      rsp_valid <= accept || (rsp_valid && !rsp.ready);
    end
  end

  // Response payload register
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.data     <= data_next;
      rsp.status   <= status_next;
      rsp.length   <= LEN_W'(count_next);
      rsp.is_empty <= (count_next == '0);
      rsp.total    <= sum_next;
    end
  end

  assign rsp.valid = rsp_valid;

endmodule
